// File: rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mbe_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REAL_START = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REAL_STEP  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAG_START = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ITER_LIMIT = 3'd4;

    localparam int COLOUR_BITS = 8;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch pixel coordinates
        logic coord_mul;   // index * step
        logic coord_add;   // start + product, clamp, clear z and count
        logic iter_mul;    // square and cross products of z
        logic iter_eval;   // magnitude test and z update
        logic finish;      // move result into the output register
    } mbe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic iter_more;   // limit not reached and |z|^2 below 4.0
    } mbe_stat_t;

endpackage

// File: rtl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: configuration registers,
// output register and stream ports. Depends on mbe_pkg, mbe_ctrl, mbe_dpath.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one transfer names one pixel by column and row.
//   Output stream (m_axis_*): one transfer per pixel with the iteration
//   count, the escaped flag and the palette index (count modulo 256).
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr at the
//   clock edge (0 real start, 1 real step, 2 imag start, 3 imag step,
//   4 iteration limit); other indexes are dropped. Write only while idle.
// Timing
//   One pixel is worked at a time. After the input transfer, c is formed
//   (multiply, then add and clamp), then each iteration registers the
//   three z products, then runs the magnitude test and the z update. The
//   next pixel is taken in the cycle after the result moves into the
//   output register.
// Reset and stall
//   rst_n clears the sequencer and the output valid and loads the default
//   view (-2.0 start, 2^-10 step on both axes, limit 100000).
//   A result waits in the output register while m_axis_tready is low; the
//   block keeps accepting and working the next pixel, and holds that one
//   until the register frees up.

module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 17,
    localparam int CFG_DATA_BITS  = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS,
    localparam int IN_DATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_FIELD_BITS = COUNT_BITS + 1 + COLOUR_BITS,
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // pixel_column, pixel_row (lowest bits first), zero padded
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // iteration_count, escaped, colour_index (lowest bits first), zero padded
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int FRAC_BITS = VALUE_BITS - 5;

    // reset view: -2.0 start, 2^-10 step
    localparam logic signed [VALUE_BITS-1:0] START_RESET =
        -(VALUE_BITS'(2) <<< FRAC_BITS);
    localparam logic signed [VALUE_BITS-1:0] STEP_RESET =
        VALUE_BITS'(1) <<< (FRAC_BITS - 10);
    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(32'd100000);

    logic signed [VALUE_BITS-1:0] real_start_reg;
    logic signed [VALUE_BITS-1:0] real_step_reg;
    logic signed [VALUE_BITS-1:0] imag_start_reg;
    logic signed [VALUE_BITS-1:0] imag_step_reg;
    logic [COUNT_BITS-1:0]        iter_limit_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_escaped_reg;

    mbe_cmd_t              cmd;
    mbe_stat_t             stat;
    logic                  out_free;
    logic [COUNT_BITS-1:0] dp_count;
    logic                  dp_escaped;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg <= START_RESET;
            real_step_reg  <= STEP_RESET;
            imag_start_reg <= START_RESET;
            imag_step_reg  <= STEP_RESET;
            iter_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_REAL_START: real_start_reg <= cfg_wdata[VALUE_BITS-1:0];
                REG_REAL_STEP:  real_step_reg  <= cfg_wdata[VALUE_BITS-1:0];
                REG_IMAG_START: imag_start_reg <= cfg_wdata[VALUE_BITS-1:0];
                REG_IMAG_STEP:  imag_step_reg  <= cfg_wdata[VALUE_BITS-1:0];
                REG_ITER_LIMIT: iter_limit_reg <= cfg_wdata[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // output register frees up on the cycle its transfer completes
    assign out_free = !out_valid_reg || m_axis_tready;

    mbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbe_dpath #(
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk             (clk),
        .cmd             (cmd),
        .stat            (stat),
        .pixel_column    (s_axis_tdata[COORD_BITS-1:0]),
        .pixel_row       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .real_start      (real_start_reg),
        .real_step       (real_step_reg),
        .imag_start      (imag_start_reg),
        .imag_step       (imag_step_reg),
        .iteration_limit (iter_limit_reg),
        .iteration_count (dp_count),
        .escaped         (dp_escaped)
    );

    // output valid: set on a finished pixel, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload: advance only when a new result is loaded
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_count_reg   <= dp_count;
            out_escaped_reg <= dp_escaped;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_count_reg[COLOUR_BITS-1:0],
                                           out_escaped_reg,
                                           out_count_reg});

endmodule

// File: rtl/mbe_ctrl.sv
// Sequencer for the escape-time block: steps one pixel through the
// coordinate and iteration phases. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_free,
    input  mbe_stat_t stat,
    output mbe_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMUL   = 3'd1;
    localparam logic [2:0] ST_CADD   = 3'd2;
    localparam logic [2:0] ST_IMUL   = 3'd3;
    localparam logic [2:0] ST_IEVAL  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CMUL;
                end
            end
            ST_CMUL:
            begin
                cmd.coord_mul = 1'b1;
                state_next    = ST_CADD;
            end
            ST_CADD:
            begin
                cmd.coord_add = 1'b1;
                state_next    = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = ST_IEVAL;
            end
            ST_IEVAL:
            begin
                cmd.iter_eval = 1'b1;
                state_next    = stat.iter_more ? ST_IMUL : ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                cmd.finish = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mbe_dpath.sv
// Datapath of the escape-time block: coordinate mapping with clamp,
// complex square-and-add iteration, magnitude test. Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_dpath
    import mbe_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 17
)
(
    input  logic                         clk,
    input  mbe_cmd_t                     cmd,
    output mbe_stat_t                    stat,
    input  logic [COORD_BITS-1:0]        pixel_column,
    input  logic [COORD_BITS-1:0]        pixel_row,
    input  logic signed [VALUE_BITS-1:0] real_start,
    input  logic signed [VALUE_BITS-1:0] real_step,
    input  logic signed [VALUE_BITS-1:0] imag_start,
    input  logic signed [VALUE_BITS-1:0] imag_step,
    input  logic [COUNT_BITS-1:0]        iteration_limit,
    output logic [COUNT_BITS-1:0]        iteration_count,
    output logic                         escaped
);

    localparam int FRAC_BITS  = VALUE_BITS - 5;
    localparam int CPROD_BITS = VALUE_BITS + COORD_BITS + 1;
    localparam int CSUM_BITS  = CPROD_BITS + 1;
    localparam int ZPROD_BITS = 2 * VALUE_BITS;
    localparam int MAG_BITS   = ZPROD_BITS + 1;

    // +8.0 in the wide coordinate sum
    localparam logic signed [CSUM_BITS-1:0] C_LIM =
        {{(CSUM_BITS-VALUE_BITS+1){1'b0}}, 1'b1, {(VALUE_BITS-2){1'b0}}};
    // 4.0 at the scale of a full product
    localparam logic [MAG_BITS-1:0] MAG_FOUR =
        {{(MAG_BITS-2*FRAC_BITS-3){1'b0}}, 1'b1, {(2*FRAC_BITS+2){1'b0}}};

    logic [COORD_BITS-1:0]        col_reg;
    logic [COORD_BITS-1:0]        row_reg;
    logic signed [CPROD_BITS-1:0] cprod_r_reg;
    logic signed [CPROD_BITS-1:0] cprod_i_reg;
    logic signed [VALUE_BITS-1:0] cr_reg;
    logic signed [VALUE_BITS-1:0] ci_reg;
    logic signed [VALUE_BITS-1:0] zr_reg;
    logic signed [VALUE_BITS-1:0] zi_reg;
    logic signed [ZPROD_BITS-1:0] p_rr_reg;
    logic signed [ZPROD_BITS-1:0] p_ii_reg;
    logic signed [ZPROD_BITS-1:0] p_ri_reg;
    logic [COUNT_BITS-1:0]        count_reg;
    logic                         escaped_reg;

    logic signed [CPROD_BITS-1:0] col_ext;
    logic signed [CPROD_BITS-1:0] row_ext;
    logic signed [CPROD_BITS-1:0] rstep_ext;
    logic signed [CPROD_BITS-1:0] istep_ext;
    logic signed [CSUM_BITS-1:0]  csum_r;
    logic signed [CSUM_BITS-1:0]  csum_i;
    logic signed [CSUM_BITS-1:0]  cclamp_r;
    logic signed [CSUM_BITS-1:0]  cclamp_i;
    logic signed [ZPROD_BITS-1:0] zr_ext;
    logic signed [ZPROD_BITS-1:0] zi_ext;
    logic signed [ZPROD_BITS-1:0] nr_full;
    logic signed [ZPROD_BITS-1:0] ni_full;
    logic [MAG_BITS-1:0]          mag;
    logic                         mag_out;

    always_comb
    begin
        col_ext   = CPROD_BITS'($signed({1'b0, col_reg}));
        row_ext   = CPROD_BITS'($signed({1'b0, row_reg}));
        rstep_ext = CPROD_BITS'(real_step);
        istep_ext = CPROD_BITS'(imag_step);

        csum_r = CSUM_BITS'(real_start) + CSUM_BITS'(cprod_r_reg);
        csum_i = CSUM_BITS'(imag_start) + CSUM_BITS'(cprod_i_reg);

        // saturate each part of c to +-8.0
        if (csum_r > C_LIM)
            cclamp_r = C_LIM;
        else if (csum_r < -C_LIM)
            cclamp_r = -C_LIM;
        else
            cclamp_r = csum_r;

        if (csum_i > C_LIM)
            cclamp_i = C_LIM;
        else if (csum_i < -C_LIM)
            cclamp_i = -C_LIM;
        else
            cclamp_i = csum_i;

        // floor-truncated products back to the value format
        nr_full = (p_rr_reg >>> FRAC_BITS) - (p_ii_reg >>> FRAC_BITS)
                  + ZPROD_BITS'(cr_reg);
        ni_full = (p_ri_reg >>> (FRAC_BITS - 1)) + ZPROD_BITS'(ci_reg);

        // squares are never negative
        mag     = {1'b0, p_rr_reg} + {1'b0, p_ii_reg};
        mag_out = (mag >= MAG_FOUR);

        zr_ext = ZPROD_BITS'(zr_reg);
        zi_ext = ZPROD_BITS'(zi_reg);
    end

    assign stat.iter_more = (count_reg < iteration_limit) && !mag_out;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= pixel_column;
            row_reg <= pixel_row;
        end
        if (cmd.coord_mul)
        begin
            cprod_r_reg <= rstep_ext * col_ext;
            cprod_i_reg <= istep_ext * row_ext;
        end
        if (cmd.coord_add)
        begin
            cr_reg    <= cclamp_r[VALUE_BITS-1:0];
            ci_reg    <= cclamp_i[VALUE_BITS-1:0];
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (cmd.iter_mul)
        begin
            p_rr_reg <= zr_ext * zr_ext;
            p_ii_reg <= zi_ext * zi_ext;
            p_ri_reg <= zr_ext * zi_ext;
        end
        if (cmd.iter_eval)
        begin
            escaped_reg <= mag_out;
            if (stat.iter_more)
            begin
                zr_reg    <= nr_full[VALUE_BITS-1:0];
                zi_reg    <= ni_full[VALUE_BITS-1:0];
                count_reg <= count_reg + COUNT_BITS'(1);
            end
        end
    end

    assign iteration_count = count_reg;
    assign escaped         = escaped_reg;

endmodule

// File: tb/tb_mandelbrot_escape_time.sv
// Self-checking bench for mandelbrot_escape_time: drives pixel transfers and register
// writes, predicts every escape-time result and compares it field by field.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

    import mbe_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 17;
    localparam int FRAC       = VALUE_BITS - 5;

    // c is clamped to +-8.0; the loop stops once |z|^2 reaches 4.0
    localparam longint AXIS_LIMIT     = longint'(8) <<< FRAC;
    localparam longint ESCAPE_RADIUS2 = longint'(4) <<< (2 * FRAC);

    // Power-on view: -2.0 start and 2^-10 step on both axes, limit 100000
    localparam logic [VALUE_BITS-1:0] DEFAULT_START = 32'hF000_0000;
    localparam logic [VALUE_BITS-1:0] DEFAULT_STEP  = 32'h0002_0000;
    localparam logic [COUNT_BITS-1:0] DEFAULT_LIMIT = 17'd100000;
    localparam logic [COUNT_BITS-1:0] MAX_LIMIT     = 17'h1FFFF;

    // receiver hold-off used to back up the block; covers two pixels at limit 1024
    localparam int LONG_HOLD = 5000;

    // s_axis_tdata layout from the top down: row, column
    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] column;
    } pixel_t;

    // m_axis_tdata layout from the top down: colour_index, escaped, iteration_count
    typedef struct packed {
        logic [COLOUR_BITS-1:0] colour_index;
        logic                   escaped;
        logic [COUNT_BITS-1:0]  iteration_count;
    } escape_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] real_start;
        logic [VALUE_BITS-1:0] real_step;
        logic [VALUE_BITS-1:0] imag_start;
        logic [VALUE_BITS-1:0] imag_step;
        logic [COUNT_BITS-1:0] iteration_limit;
    } view_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic [2*COORD_BITS-1:0]  s_axis_tdata  = '0;   // pixel_column, pixel_row
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [31:0]              m_axis_tdata;         // iteration_count, escaped, colour_index
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic                     cfg_we        = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr      = '0;
    logic [VALUE_BITS-1:0]    cfg_wdata     = '0;

    // Bench copy of the register file; changes only while the block is idle
    view_t   view;
    pixel_t  pending_pixels[$];
    escape_t expected_escapes[$];
    pixel_t  offered_pixel;
    escape_t got_escape;
    escape_t want_escape;
    bit      idle_on      = 1'b0;
    int      send_gap     = 0;
    int      stall_left   = 0;
    int      results_done = 0;
    int      hold_at      = -1;
    int      failures     = 0;

    mandelbrot_escape_time #(
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // start + index * step at full width, then clamp to +-8.0
    function automatic longint clamp_axis(input logic [VALUE_BITS-1:0] start,
                                          input logic [VALUE_BITS-1:0] step,
                                          input logic [COORD_BITS-1:0] index);
        longint c;
        c = longint'($signed(start)) + longint'(index) * longint'($signed(step));
        if (c > AXIS_LIMIT)
            c = AXIS_LIMIT;
        if (c < -AXIS_LIMIT)
            c = -AXIS_LIMIT;
        return c;
    endfunction

    // Iterate z = z*z + c from zero. Each product is floored back to the value
    // format; the escape test uses the full-width sum of squares.
    function automatic escape_t escape_time(input pixel_t px, input view_t v);
        longint  cr, ci, zr, zi, rr, ii, ri2, mag;
        int      count;
        escape_t r;
        cr    = clamp_axis(v.real_start, v.real_step, px.column);
        ci    = clamp_axis(v.imag_start, v.imag_step, px.row);
        zr    = 0;
        zi    = 0;
        mag   = 0;
        count = 0;
        while (count < int'(v.iteration_limit) && mag < ESCAPE_RADIUS2)
        begin
            rr    = (zr * zr) >>> FRAC;
            ii    = (zi * zi) >>> FRAC;
            ri2   = (zr * zi) >>> (FRAC - 1);
            zr    = rr - ii + cr;
            zi    = ri2 + ci;
            mag   = zr * zr + zi * zi;
            count = count + 1;
        end
        r.iteration_count = count[COUNT_BITS-1:0];
        r.escaped         = (mag >= ESCAPE_RADIUS2);
        r.colour_index    = count[COLOUR_BITS-1:0];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // Sender: hold each pixel until its transfer, predict at the transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_escapes.push_back(escape_time(offered_pixel, view));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 3) == 0)
                begin
                    send_gap = pick_gap() - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    offered_pixel = pending_pixels.pop_front();
                    s_axis_tdata  <= offered_pixel;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Receiver: check each result transfer against the oldest prediction,
    // then pick tready for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_escape = m_axis_tdata[$bits(escape_t)-1:0];
                if (expected_escapes.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding: %h", m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want_escape = expected_escapes.pop_front();
                    if (got_escape.iteration_count != want_escape.iteration_count)
                    begin
                        $error("iteration_count expected %0d got %0d",
                               want_escape.iteration_count, got_escape.iteration_count);
                        failures++;
                    end
                    if (got_escape.escaped != want_escape.escaped)
                    begin
                        $error("escaped expected %0d got %0d",
                               want_escape.escaped, got_escape.escaped);
                        failures++;
                    end
                    if (got_escape.colour_index != want_escape.colour_index)
                    begin
                        $error("colour_index expected %0d got %0d",
                               want_escape.colour_index, got_escape.colour_index);
                        failures++;
                    end
                end
                results_done++;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (results_done == hold_at)
            begin
                // long hold-off: the block finishes the next pixel, parks it and
                // must stall its input while the sender keeps offering
                hold_at       = -1;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left    = pick_gap() - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Register write at the next edge; the bench copy follows at once since
    // no pixel is in flight while registers change
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [VALUE_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_REAL_START: view.real_start      = data;
            REG_REAL_STEP:  view.real_step       = data;
            REG_IMAG_START: view.imag_start      = data;
            REG_IMAG_STEP:  view.imag_step       = data;
            REG_ITER_LIMIT: view.iteration_limit = data[COUNT_BITS-1:0];
            default:        ;
        endcase
    endtask

    // Drop the write enable and come back at a falling edge
    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Write all five registers; limit_pad fills the unused upper bits of the limit
    task automatic load_view(input view_t v, input logic [14:0] limit_pad);
        write_reg(REG_REAL_START, v.real_start);
        write_reg(REG_REAL_STEP,  v.real_step);
        write_reg(REG_IMAG_START, v.imag_start);
        write_reg(REG_IMAG_STEP,  v.imag_step);
        write_reg(REG_ITER_LIMIT, {limit_pad, v.iteration_limit});
        end_writes();
    endtask

    task automatic add_pixel(input logic [COORD_BITS-1:0] column,
                             input logic [COORD_BITS-1:0] row);
        pixel_t px;
        px.column = column;
        px.row    = row;
        pending_pixels.push_back(px);
    endtask

    // Poll on falling edges until every pixel went in and every result came out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_escapes.size() != 0);
    endtask

    initial
    begin
        view_t   v;
        pixel_t  probe_px;
        escape_t probe;
        int      tries;
        int      phase;
        int      a;

        view.real_start      = DEFAULT_START;
        view.real_step       = DEFAULT_STEP;
        view.imag_start      = DEFAULT_START;
        view.imag_step       = DEFAULT_STEP;
        view.iteration_limit = DEFAULT_LIMIT;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Power-on view: corners escape fast, c = -1 stays bounded up to 100000
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd2560, 12'd2048);
        add_pixel(12'd1024, 12'd2048);
        wait_idle();

        // Zero limit: no iteration at all
        idle_on = 1'b1;
        write_reg(REG_ITER_LIMIT, '0);
        end_writes();
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd2048, 12'd2048);
        add_pixel(12'd4095, 12'd0);
        wait_idle();

        // Limit of one; writes to unmapped indexes must leave the view alone
        write_reg(REG_ITER_LIMIT, 32'd1);
        for (a = int'(REG_ITER_LIMIT) + 1; a < (1 << CFG_ADDR_BITS); a++)
            write_reg(CFG_ADDR_BITS'(a), $urandom());
        end_writes();
        add_pixel(12'd0, 12'd0);        // escapes on the one allowed iteration
        add_pixel(12'd2048, 12'd2048);  // c = 0, stops at the limit
        wait_idle();

        // Far coordinates: extreme starts and steps clamp to +-8.0
        v.real_start      = 32'h7FFF_FFFF;
        v.real_step       = 32'h7FFF_FFFF;
        v.imag_start      = 32'h8000_0000;
        v.imag_step       = 32'h8000_0000;
        v.iteration_limit = 17'd16;
        load_view(v, 15'h7FFF);
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd4095, 12'd0);
        add_pixel(12'd0, 12'd4095);
        wait_idle();

        v.real_start = '0;
        v.real_step  = 32'h8000_0000;
        v.imag_start = '0;
        v.imag_step  = 32'h7FFF_FFFF;
        load_view(v, 15'h0);
        add_pixel(12'd4095, 12'd4095);
        add_pixel(12'd1, 12'd1);
        add_pixel(12'd0, 12'd0);
        wait_idle();

        // Escape on the last iteration: find a pixel that escapes after a few
        // iterations, set the limit to exactly that count, then one below
        v.real_start      = DEFAULT_START;
        v.real_step       = DEFAULT_STEP;
        v.imag_start      = DEFAULT_START;
        v.imag_step       = DEFAULT_STEP;
        v.iteration_limit = 17'd4000;
        tries = 0;
        do
        begin
            probe_px.column = COORD_BITS'($urandom_range(0, 4095));
            probe_px.row    = COORD_BITS'($urandom_range(0, 4095));
            probe           = escape_time(probe_px, v);
            tries++;
        end
        while ((!probe.escaped || probe.iteration_count < 3 ||
                probe.iteration_count > 2000) && tries < 500);
        v.iteration_limit = probe.iteration_count;
        load_view(v, 15'h0);
        add_pixel(probe_px.column, probe_px.row);
        wait_idle();
        write_reg(REG_ITER_LIMIT, 32'(probe.iteration_count - 1'b1));
        end_writes();
        add_pixel(probe_px.column, probe_px.row);
        wait_idle();

        // Largest limit: c = 0 runs the whole way, the far corner escapes
        idle_on      = 1'b0;
        v.real_start = '0;
        v.imag_start = '0;
        v.iteration_limit = MAX_LIMIT;
        load_view(v, 15'h5555);
        add_pixel(12'd0, 12'd0);
        add_pixel(12'd4095, 12'd4095);
        wait_idle();

        // Random views: mostly a window over the set with small limits, now
        // and then raw register values; pixels cover the whole index range
        for (phase = 0; phase < 5; phase++)
        begin
            idle_on = (phase != 2);
            if (phase != 0 && $urandom_range(0, 3) == 0)
            begin
                v.real_start = $urandom();
                v.real_step  = $urandom();
                v.imag_start = $urandom();
                v.imag_step  = $urandom();
            end
            else
            begin
                v.real_start = 32'(-(2 <<< FRAC) + int'($urandom_range(0, 1 << 26)) - (1 << 25));
                v.real_step  = $urandom_range(1 << 9, 1 << 17);
                v.imag_start = 32'(-(2 <<< FRAC) + int'($urandom_range(0, 1 << 26)) - (1 << 25));
                v.imag_step  = $urandom_range(1 << 9, 1 << 17);
            end
            if ($urandom_range(0, 4) == 0)
                v.iteration_limit = COUNT_BITS'($urandom_range(1, 1024));
            else
                v.iteration_limit = COUNT_BITS'($urandom_range(1, 300));
            load_view(v, 15'($urandom()));
            if (phase == 0)
                hold_at = results_done + 8;
            repeat (20)
                add_pixel(COORD_BITS'($urandom_range(0, 4095)),
                          COORD_BITS'($urandom_range(0, 4095)));
            wait_idle();
        end

        // Let any stray result show up before the verdict
        repeat (50) @(posedge clk);
        if (failures == 0 && expected_escapes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial
    begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
